FILE: rtl/multilevel_queue_rr_fcfs_scheduler_unit_defines.svh
`ifndef MULTILEVEL_QUEUE_RR_FCFS_SCHEDULER_UNIT_DEFINES_SVH
`define MULTILEVEL_QUEUE_RR_FCFS_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MLQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MLQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mlq_sched_pkg.sv
package mlq_sched_pkg;

  localparam int BURST_BITS = 16;
  localparam int TIME_BITS  = 22;
  localparam int QUANT_BITS = 16;
  localparam int PIDX_BITS  = 6;

  localparam logic [QUANT_BITS-1:0] QUANT_RESET = QUANT_BITS'(4);

  // apb register map
  localparam logic REG_QUANTUM = 1'b0;

  typedef enum logic {
    CLASS_RR   = 1'b0,
    CLASS_FCFS = 1'b1
  } queue_class_t;

  typedef struct packed {
    logic [BURST_BITS-1:0] burst_time;
    logic                  queue_class;
    logic                  last_process;
  } in_data_t;

  typedef struct packed {
    logic [PIDX_BITS-1:0]  process_index;
    logic [BURST_BITS-1:0] burst_echo;
    logic [TIME_BITS-1:0]  waiting_time;
    logic [TIME_BITS-1:0]  turnaround_time;
    logic                  last_result;
  } out_data_t;

  // one process table entry
  typedef struct packed {
    logic [BURST_BITS-1:0] burst;
    logic [BURST_BITS-1:0] remaining;
    logic                  cls;
    logic [TIME_BITS-1:0]  finish;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RR_RD,
    ST_RR_WR,
    ST_FC_RD,
    ST_FC_WR,
    ST_EMIT,
    ST_DRAIN
  } sched_state_t;

endpackage

FILE: rtl/mlq_sched_ram.sv
module mlq_sched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/multilevel_queue_rr_fcfs_scheduler_unit.sv
// Multilevel queue scheduler. Processes are loaded one per cycle while busy is low; the
// load with last_process set closes the set and starts scheduling, during which busy is
// high. The process table sits in one single-port-write RAM, and every scheduling step is a
// read state followed by a modify/write state, so each visit of an entry takes both states.
// Round robin takes ceil(max_rr_burst / quantum) passes over the n entries (at least one pass),
// first come first served takes one pass, then the n results follow without gaps, each
// read through the table RAM and the result register in turn. out_valid marks each result
// for exactly one cycle; the receiver has no way to stall, so it must take every result
// as it appears. busy drops while the last result is still on the outputs, and a new set
// may start loading then. A quantum of 0 behaves as 1.
`include "multilevel_queue_rr_fcfs_scheduler_unit_defines.svh"

module multilevel_queue_rr_fcfs_scheduler_unit #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  mlq_sched_pkg::in_data_t  in_data,
  output logic                   out_valid,
  output mlq_sched_pkg::out_data_t out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam int EW = $bits(mlq_sched_pkg::entry_t);
  localparam int BB = mlq_sched_pkg::BURST_BITS;
  localparam int TB = mlq_sched_pkg::TIME_BITS;
  localparam int QB = mlq_sched_pkg::QUANT_BITS;

  mlq_sched_pkg::sched_state_t state_r, state_nxt;
  logic [QB-1:0]  quantum_r, quantum_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [TB-1:0]  time_r, time_nxt;
  logic           more_r, more_nxt;
  logic           rd_v_r, rd_v_nxt;
  logic [AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  mlq_sched_pkg::out_data_t out_data_r, out_data_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [EW-1:0]  ram_wdata, ram_rdata;
  mlq_sched_pkg::entry_t rd_entry, wr_entry;

  logic           in_accept, has_room, cfg_wr, idx_last, more_any;
  logic [QB-1:0]  q_eff;
  logic           rr_active, fc_active;
  logic [BB-1:0]  slice, rem_new;
  logic [TB-1:0]  rr_time, fc_time;
  logic [TB-1:0]  tat, wt;

  mlq_sched_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PROCESSES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry  = mlq_sched_pkg::entry_t'(ram_rdata);
  assign in_accept = start && !busy;
  assign has_room  = (count_r < CW'(MAX_PROCESSES));
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign idx_last  = (CW'(idx_r) == (count_r - CW'(1)));
  assign q_eff     = (quantum_r == '0) ? QB'(1) : quantum_r;

  // round robin turn on the entry just read
  assign rr_active = (rd_entry.cls == mlq_sched_pkg::CLASS_RR) && (rd_entry.remaining != '0);
  assign slice     = (rd_entry.remaining > BB'(q_eff)) ? BB'(q_eff) : rd_entry.remaining;
  assign rem_new   = rd_entry.remaining - slice;
  assign rr_time   = time_r + TB'(slice);
  assign more_any  = more_r || (rr_active && (rem_new != '0));

  assign fc_active = (rd_entry.cls == mlq_sched_pkg::CLASS_FCFS) &&
                     (rd_entry.remaining != '0);
  assign fc_time   = time_r + TB'(rd_entry.remaining);

  // zero-burst processes never ran and report zeros
  assign tat = (rd_entry.burst == '0) ? '0 : rd_entry.finish;
  assign wt  = tat - TB'(rd_entry.burst);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlq_sched_pkg::ST_IDLE: begin
        if (in_accept && in_data.last_process) begin
          state_nxt = mlq_sched_pkg::ST_RR_RD;
        end
      end
      mlq_sched_pkg::ST_RR_RD: state_nxt = mlq_sched_pkg::ST_RR_WR;
      mlq_sched_pkg::ST_RR_WR: begin
        if (!idx_last) begin
          state_nxt = mlq_sched_pkg::ST_RR_RD;
        end else if (more_any) begin
          state_nxt = mlq_sched_pkg::ST_RR_RD;
        end else begin
          state_nxt = mlq_sched_pkg::ST_FC_RD;
        end
      end
      mlq_sched_pkg::ST_FC_RD: state_nxt = mlq_sched_pkg::ST_FC_WR;
      mlq_sched_pkg::ST_FC_WR: begin
        state_nxt = idx_last ? mlq_sched_pkg::ST_EMIT : mlq_sched_pkg::ST_FC_RD;
      end
      mlq_sched_pkg::ST_EMIT: begin
        if (idx_last) begin
          state_nxt = mlq_sched_pkg::ST_DRAIN;
        end
      end
      mlq_sched_pkg::ST_DRAIN: state_nxt = mlq_sched_pkg::ST_IDLE;
      default: state_nxt = mlq_sched_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    time_nxt      = time_r;
    more_nxt      = more_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_raddr     = idx_r;
    wr_entry      = rd_entry;
    quantum_nxt   = quantum_r;

    if (cfg_wr && (paddr[2] == mlq_sched_pkg::REG_QUANTUM)) begin
      quantum_nxt = pwdata[QB-1:0];
    end

    case (state_r)
      mlq_sched_pkg::ST_IDLE: begin
        wr_entry.burst     = in_data.burst_time;
        wr_entry.remaining = in_data.burst_time;
        wr_entry.cls       = in_data.queue_class;
        wr_entry.finish    = '0;
        ram_waddr          = count_r[AW-1:0];
        idx_nxt            = '0;
        more_nxt           = 1'b0;
        if (in_accept && has_room) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      mlq_sched_pkg::ST_RR_WR: begin
        wr_entry.remaining = rem_new;
        if (rem_new == '0) begin
          wr_entry.finish = rr_time;
        end
        if (rr_active) begin
          ram_we   = 1'b1;
          time_nxt = rr_time;
        end
        if (idx_last) begin
          idx_nxt  = '0;
          more_nxt = 1'b0;
        end else begin
          idx_nxt  = idx_r + AW'(1);
          more_nxt = more_any;
        end
      end
      mlq_sched_pkg::ST_FC_WR: begin
        wr_entry.remaining = '0;
        wr_entry.finish    = fc_time;
        if (fc_active) begin
          ram_we   = 1'b1;
          time_nxt = fc_time;
        end
        idx_nxt = idx_last ? '0 : (idx_r + AW'(1));
      end
      mlq_sched_pkg::ST_EMIT: begin
        rd_v_nxt   = 1'b1;
        rd_idx_nxt = idx_r;
        if (!idx_last) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      mlq_sched_pkg::ST_DRAIN: begin
        count_nxt = '0;
        time_nxt  = '0;
        idx_nxt   = '0;
      end
      default: begin
      end
    endcase

    ram_wdata = EW'(wr_entry);
  end

  // result register
  always_comb begin
    out_valid_nxt                = rd_v_r;
    out_data_nxt.process_index   = mlq_sched_pkg::PIDX_BITS'(rd_idx_r);
    out_data_nxt.burst_echo      = rd_entry.burst;
    out_data_nxt.waiting_time    = wt;
    out_data_nxt.turnaround_time = tat;
    out_data_nxt.last_result     = (CW'(rd_idx_r) == (count_r - CW'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlq_sched_pkg::ST_IDLE;
      quantum_r   <= mlq_sched_pkg::QUANT_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      time_r      <= '0;
      more_r      <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      quantum_r   <= quantum_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      time_r      <= time_nxt;
      more_r      <= more_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != mlq_sched_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == mlq_sched_pkg::REG_QUANTUM) ? {16'b0, quantum_r} : 32'b0;

  `MLQ_ASSERT_NEXT(a_last_ends_burst, out_valid_r && out_data_r.last_result, !out_valid_r, "result after last")
  `MLQ_ASSERT_NEXT(a_results_contig, out_valid_r && !out_data_r.last_result, out_valid_r, "gap in results")
  `MLQ_ASSERT_IMP(a_first_index, $rose(out_valid_r), out_data_r.process_index == '0, "first result index")
  `MLQ_ASSERT_NEXT(a_last_load_busy, start && !busy && in_data.last_process, busy, "no schedule after last")
  `MLQ_ASSERT_IMP(a_wait_le_tat, out_valid_r, out_data_r.waiting_time <= out_data_r.turnaround_time, "wait above tat")

endmodule
